FILE: rtl/yrr_pkg.sv
`timescale 1ns / 1ps

package yrr_pkg;

    // Field widths of the pixel stream.
    localparam int PIX_W  = 8;
    localparam int RGB_W  = 16;
    localparam int ADDR_W = 24;

    // Configuration port shape.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Reset values of the dimension registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd400;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd240;

    // Width of the signed Q12 channel sums.
    localparam int SUM_W = 24;

    typedef logic signed [SUM_W-1:0] csum_t;

    // Q12 conversion coefficients.
    localparam csum_t COEF_RV = 24'sd5614;
    localparam csum_t COEF_GV = 24'sd2859;
    localparam csum_t COEF_GU = 24'sd1383;
    localparam csum_t COEF_BU = 24'sd7096;

    localparam logic signed [PIX_W:0] CHROMA_OFFSET = 9'sd128;
    localparam logic [PIX_W-1:0]      CHAN_MAX      = 8'hFF;

    // Drop the Q12 fraction and saturate a channel sum to 0..255.
    function automatic logic [PIX_W-1:0] clamp_q12(input csum_t sum);
        logic [SUM_W-13:0] whole;
        whole = sum[SUM_W-1:12];
        if (sum < 0) begin
            return '0;
        end
        else if (whole > (SUM_W-12)'(CHAN_MAX)) begin
            return CHAN_MAX;
        end
        else begin
            return whole[PIX_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/yuv420_to_rgb565_rotate_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake           | Word
// ----------+-----------+---------------------+----------------------------------
// in        | input     | in_valid / in_stall | luma, chroma_blue, chroma_red
// out       | output    | out_valid/out_stall | rgb_pixel, dest_address, frame_end
// cfg       | input     | cfg_we              | cfg_index, cfg_data
//
// One word is taken per clock while in_stall is low. An accepted word sits in the input
// register and moves on to the result register behind the multiplier once that register
// can take it, so its result is presented from the result register.
// The address multiplier and the color sums each sit in one register-to-register
// stage. Reset clears the counters and the valid flags and returns the dimension
// registers to 400 by 240.
// A stall on the output holds the result register and backs up into in_stall.

module yuv420_to_rgb565_rotate_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [yrr_pkg::PIX_W-1:0]     luma,
    input  logic [yrr_pkg::PIX_W-1:0]     chroma_blue,
    input  logic [yrr_pkg::PIX_W-1:0]     chroma_red,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [yrr_pkg::RGB_W-1:0]     rgb_pixel,
    output logic [yrr_pkg::ADDR_W-1:0]    dest_address,
    output logic                          frame_end,
    input  logic                          cfg_we,
    input  logic [yrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrr_pkg::CFG_W-1:0]     cfg_data
);
    import yrr_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int EXT_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int PROD_W = CNT_W + DIM_W;
    localparam int ASUM_W = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    // A zero dimension counts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext == '0) begin
            return DIM_W'(1);
        end
        else if (ext > EXT_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        else begin
            return DIM_W'(ext);
        end
    endfunction

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;

    logic             s0_valid_reg;
    logic [PIX_W-1:0] s0_luma_reg;
    logic [PIX_W-1:0] s0_cb_reg;
    logic [PIX_W-1:0] s0_cr_reg;
    logic [CNT_W-1:0] s0_col_reg;
    logic [CNT_W-1:0] s0_row_reg;
    logic             s0_last_reg;

    logic              out_valid_reg;
    logic [RGB_W-1:0]  rgb_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              last_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] w_m1;
    logic [DIM_W-1:0] h_m1;
    logic [CNT_W-1:0] col_eff;
    logic [CNT_W-1:0] row_eff;
    logic             col_wrap;
    logic             row_wrap;
    logic             in_accept;
    logic             adv1;

    logic signed [PIX_W:0] u_s;
    logic signed [PIX_W:0] v_s;
    csum_t                 ys;
    csum_t                 sum_r;
    csum_t                 sum_g;
    csum_t                 sum_b;
    logic [PIX_W-1:0]      chan_r;
    logic [PIX_W-1:0]      chan_g;
    logic [PIX_W-1:0]      chan_b;
    logic [PROD_W-1:0]     addr_prod;
    logic [DIM_W-1:0]      addr_line;
    logic [ASUM_W-1:0]     addr_sum;

    // Handshake: stage 0 empties when the result register can take its word.
    assign adv1      = s0_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s0_valid_reg && !adv1;
    assign in_accept = in_valid && !in_stall;

    // Effective frame dimensions.
    assign w_eff = eff_dim(frame_width_reg);
    assign h_eff = eff_dim(frame_height_reg);
    assign w_m1  = w_eff - DIM_W'(1);
    assign h_m1  = h_eff - DIM_W'(1);

    // Raster counters, pulled back in range after a dimension change.
    always_comb
    begin
        col_eff  = (DIM_W'(col_reg) >= w_eff) ? '0 : col_reg;
        row_eff  = (DIM_W'(row_reg) >= h_eff) ? '0 : row_reg;
        col_wrap = (DIM_W'(col_eff) == w_m1);
        row_wrap = (DIM_W'(row_eff) == h_m1);
        col_next = col_wrap ? '0 : col_eff + CNT_W'(1);
        if (col_wrap) begin
            row_next = row_wrap ? '0 : row_eff + CNT_W'(1);
        end
        else begin
            row_next = row_eff;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Counter state and stage 0 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s0_valid_reg <= 1'b1;
            end
            else if (adv1) begin
                s0_valid_reg <= 1'b0;
            end
            if (!out_valid_reg || !out_stall) begin
                out_valid_reg <= s0_valid_reg;
            end
        end
    end

    // Stage 0 payload: samples plus the pixel's position.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s0_luma_reg <= luma;
            s0_cb_reg   <= chroma_blue;
            s0_cr_reg   <= chroma_red;
            s0_col_reg  <= col_eff;
            s0_row_reg  <= row_eff;
            s0_last_reg <= col_wrap && row_wrap;
        end
    end

    // Color matrix in Q12 with clamping.
    always_comb
    begin
        u_s    = $signed({1'b0, s0_cb_reg}) - CHROMA_OFFSET;
        v_s    = $signed({1'b0, s0_cr_reg}) - CHROMA_OFFSET;
        ys     = $signed({4'b0000, s0_luma_reg, 12'h000});
        sum_r  = ys + COEF_RV * SUM_W'(v_s);
        sum_g  = ys - COEF_GV * SUM_W'(v_s) - COEF_GU * SUM_W'(u_s);
        sum_b  = ys + COEF_BU * SUM_W'(u_s);
        chan_r = clamp_q12(sum_r);
        chan_g = clamp_q12(sum_g);
        chan_b = clamp_q12(sum_b);
    end

    // Rotated destination: column * height + (height - 1 - row).
    always_comb
    begin
        addr_prod = PROD_W'(s0_col_reg) * PROD_W'(h_eff);
        addr_line = h_m1 - DIM_W'(s0_row_reg);
        addr_sum  = ASUM_W'(addr_prod) + ASUM_W'(addr_line);
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (adv1) begin
            rgb_reg  <= {chan_r[7:3], chan_g[7:2], chan_b[7:3]};
            addr_reg <= addr_sum[ADDR_W-1:0];
            last_reg <= s0_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rgb_pixel    = rgb_reg;
    assign dest_address = addr_reg;
    assign frame_end    = last_reg;

`ifndef SYNTH
    // The input side only stalls while stage 0 holds a word.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s0_valid_reg)
        else $error("in_stall raised with stage 0 empty");

    // After an accepted word the column counter stays inside the frame.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !cfg_we |=> DIM_W'(col_reg) < w_eff)
        else $error("column counter left the frame");

    // After an accepted word the row counter stays inside the frame.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !cfg_we |=> DIM_W'(row_reg) < h_eff)
        else $error("row counter left the frame");

    // A drained result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !s0_valid_reg |=> !out_valid_reg)
        else $error("result repeated after it was taken");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import yrr_pkg::*;

    localparam int DIM_LIMIT    = 4096;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1200;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIRECTED   = 19;

    // Q12 color matrix and chroma bias.
    localparam int Q_RV  = 5614;
    localparam int Q_GV  = 2859;
    localparam int Q_GU  = 1383;
    localparam int Q_BU  = 7096;
    localparam int C_MID = 128;

    typedef struct packed {
        logic [RGB_W-1:0]  rgb;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } pixel_result_t;

    // Tracks the frame geometry and the raster position, and holds the
    // converted pixels that are still owed by the block.
    class pixel_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned      col_pos;
        int unsigned      row_pos;
        pixel_result_t    pending_pixels[$];
        int               errors;
        int               checked;
        int               frame_ends;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            checked    = 0;
            frame_ends = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_FRAME_WIDTH)
                width_reg = data;
            else if (idx == REG_FRAME_HEIGHT)
                height_reg = data;
        endfunction

        // A zero dimension acts as one; anything above the limit acts as the limit.
        function int unsigned dim_of(logic [CFG_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > DIM_LIMIT)
                return DIM_LIMIT;
            return raw;
        endfunction

        function logic [7:0] clip_channel(int sum);
            if (sum < 0)
                return 8'd0;
            if ((sum >>> 12) > 255)
                return 8'hFF;
            return 8'(sum >>> 12);
        endfunction

        function void note_word(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
            int unsigned   w;
            int unsigned   h;
            int            ys;
            int            du;
            int            dv;
            logic [7:0]    r;
            logic [7:0]    g;
            logic [7:0]    b;
            int unsigned   a;
            pixel_result_t res;
            w  = dim_of(width_reg);
            h  = dim_of(height_reg);
            ys = int'(y) * 4096;
            du = int'(cb) - C_MID;
            dv = int'(cr) - C_MID;

            // A shrunken frame pulls stale counters back to the origin.
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;

            r = clip_channel(ys + Q_RV * dv);
            g = clip_channel(ys - Q_GV * dv - Q_GU * du);
            b = clip_channel(ys + Q_BU * du);
            a = col_pos * h + (h - 1 - row_pos);

            res.rgb  = {r[7:3], g[7:2], b[7:3]};
            res.addr = a[ADDR_W-1:0];
            res.last = (col_pos == w - 1) && (row_pos == h - 1);
            pending_pixels.push_back(res);

            // Advance in raster order, wrapping at the end of the frame.
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void check_word(logic [RGB_W-1:0] rgb, logic [ADDR_W-1:0] addr,
                                 logic last);
            pixel_result_t exp_px;
            if (pending_pixels.size() == 0)
            begin
                $error("Result with no pixel pending: rgb_pixel %h dest_address %h frame_end %b",
                       rgb, addr, last);
                errors++;
                return;
            end
            exp_px = pending_pixels.pop_front();
            checked++;
            if (last === 1'b1)
                frame_ends++;
            if (rgb !== exp_px.rgb)
            begin
                $error("rgb_pixel: expected %h, got %h", exp_px.rgb, rgb);
                errors++;
            end
            if (addr !== exp_px.addr)
            begin
                $error("dest_address: expected %h, got %h", exp_px.addr, addr);
                errors++;
            end
            if (last !== exp_px.last)
            begin
                $error("frame_end: expected %b, got %b", exp_px.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     luma        = '0;
    logic [PIX_W-1:0]     chroma_blue = '0;
    logic [PIX_W-1:0]     chroma_red  = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [RGB_W-1:0]     rgb_pixel;
    logic [ADDR_W-1:0]    dest_address;
    logic                 frame_end;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data    = '0;

    pixel_scoreboard sb;
    int unsigned     cycle_count = 0;
    int unsigned     stall_pct   = 0;
    int              words_sent  = 0;
    int              burst_left  = 0;
    int              phases      = 1;

    // Corner colors: black, white, gray levels, chroma rails and mixes.
    logic [23:0] directed_words [N_DIRECTED] = '{
        24'h000000, 24'hFFFFFF, 24'h008080, 24'hFF8080, 24'h800000,
        24'h80FFFF, 24'h00FF00, 24'hFF00FF, 24'h108080, 24'hEB8080,
        24'hFF0000, 24'h0000FF, 24'h00FFFF, 24'h808000, 24'h8080FF,
        24'h800080, 24'h80FF80, 24'hAA55AA, 24'h55AA55
    };

    yuv420_to_rgb565_rotate_unit #(
        .MAX_DIM(DIM_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .luma(luma),
        .chroma_blue(chroma_blue),
        .chroma_red(chroma_red),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .rgb_pixel(rgb_pixel),
        .dest_address(dest_address),
        .frame_end(frame_end),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Output back-pressure is redrawn at random from four densities;
    // the same block guards against a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 48 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Every accepted result is checked against the oldest pending pixel.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(rgb_pixel, dest_address, frame_end);
    end

    function automatic logic [PIX_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one word and hold it until taken, then maybe close the burst.
    task automatic send_word(input logic [PIX_W-1:0] y, input logic [PIX_W-1:0] cb,
                             input logic [PIX_W-1:0] cr);
        int gap;
        luma        <= y;
        chroma_blue <= cb;
        chroma_red  <= cr;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(y, cb, cr);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Let every owed pixel come out before the frame geometry changes.
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int w, input int h, input int n,
                             input bit set_w, input bit set_h);
        settle_pipeline();
        if (set_w)
            write_dim(REG_FRAME_WIDTH, CFG_W'(w));
        if (set_h)
            write_dim(REG_FRAME_HEIGHT, CFG_W'(h));
        phases++;
        repeat (n) send_word(pick_sample(), pick_sample(), pick_sample());
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return $urandom_range(4090, 8191);
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner colors, then random pixels, at the reset frame size.
        foreach (directed_words[i])
            send_word(directed_words[i][23:16], directed_words[i][15:8],
                      directed_words[i][7:0]);
        repeat (100) send_word(pick_sample(), pick_sample(), pick_sample());

        // Narrow frame while the column counter is far past the new width.
        run_phase(16, 3, 80, 1'b1, 1'b1);
        // Zero dimensions give a one-pixel frame.
        run_phase(0, 0, 30, 1'b1, 1'b1);
        // Single column, tallest frame: the row counter climbs high.
        run_phase(1, 4096, 150, 1'b1, 1'b1);
        // Shorter frame while the row counter is beyond it.
        run_phase(1, 40, 60, 1'b0, 1'b1);
        // Oversized registers saturate to the dimension limit.
        run_phase(8191, 4097, 150, 1'b1, 1'b1);
        run_phase(4096, 1, 60, 1'b1, 1'b1);

        // Random frame sizes, sometimes changing only one dimension.
        while (words_sent < RANDOM_WORDS + N_DIRECTED)
            run_phase(pick_dim(), pick_dim(), $urandom_range(30, 120),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);

        settle_pipeline();
        $display("Converted %0d pixels with %0d frame ends over %0d frame size settings.",
                 sb.checked, sb.frame_ends, phases);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
